### rtl/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants for the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int PIX_W      = 8;
    localparam int POS_W      = 7;
    localparam int DIM_W      = 8;
    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;
    localparam int DIM_MIN    = 3;
    localparam int LS_ADDR_W  = $clog2(MAX_WIDTH);
    localparam int LS_DATA_W  = 2 * PIX_W;

    // Configuration register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // Classified pixel, passed from front to back
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [POS_W-1:0] col;
        logic             produce;
        logic [POS_W-1:0] row_o;
        logic [POS_W-1:0] col_o;
        logic             last;
    } item_t;

    // Result item
    typedef struct packed {
        logic [PIX_W-1:0] edge_value;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } res_t;

endpackage

### rtl/sem_ram.sv
// ----------------------------------------------------------------------------
// sem_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sem_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/sem_queue.sv
// ----------------------------------------------------------------------------
// sem_queue
// Two-entry item queue between the front and back parts.
// ----------------------------------------------------------------------------
module sem_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sem_pkg::item_t push_item,
    output logic          not_full,
    input  logic          pop,
    output logic          head_valid,
    output sem_pkg::item_t head_item
);

    sem_pkg::item_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign not_full   = (cnt_reg != 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head_item  = slot_reg[rd_ptr_reg];

endmodule

### rtl/sem_front.sv
// ----------------------------------------------------------------------------
// sem_front
// Accepts pixels, holds geometry registers and position counters, and
// tags each pixel with its window position and whether it yields a result.
// ----------------------------------------------------------------------------
module sem_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_index,
    input  logic [sem_pkg::DIM_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [sem_pkg::PIX_W-1:0] pixel,
    input  logic                      frame_start,
    input  logic                      q_not_full,
    output logic                      q_push,
    output sem_pkg::item_t            q_item
);

    logic [sem_pkg::DIM_W-1:0] width_reg, width_next;
    logic [sem_pkg::DIM_W-1:0] height_reg, height_next;
    logic [sem_pkg::POS_W-1:0] col_reg, col_next;
    logic [sem_pkg::POS_W-1:0] row_reg, row_next;

    logic [sem_pkg::DIM_W-1:0] w_eff;
    logic [sem_pkg::DIM_W-1:0] h_eff;
    logic [sem_pkg::POS_W-1:0] c;
    logic [sem_pkg::POS_W-1:0] r;
    logic [sem_pkg::DIM_W-1:0] c_inc;
    logic [sem_pkg::DIM_W-1:0] r_inc;

    // Decode configuration writes
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                sem_pkg::REG_IMAGE_WIDTH:  width_next  = cfg_data;
                sem_pkg::REG_IMAGE_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp geometry to the supported range
    always_comb
    begin
        if (width_reg < sem_pkg::DIM_W'(sem_pkg::DIM_MIN))
            w_eff = sem_pkg::DIM_W'(sem_pkg::DIM_MIN);
        else if (width_reg > sem_pkg::DIM_W'(sem_pkg::MAX_WIDTH))
            w_eff = sem_pkg::DIM_W'(sem_pkg::MAX_WIDTH);
        else
            w_eff = width_reg;

        if (height_reg < sem_pkg::DIM_W'(sem_pkg::DIM_MIN))
            h_eff = sem_pkg::DIM_W'(sem_pkg::DIM_MIN);
        else if (height_reg > sem_pkg::DIM_W'(sem_pkg::MAX_HEIGHT))
            h_eff = sem_pkg::DIM_W'(sem_pkg::MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    assign in_ready = q_not_full;
    assign q_push   = in_valid && q_not_full;

    // Classify the pixel and advance the raster position
    always_comb
    begin
        c = frame_start ? '0 : col_reg;
        r = frame_start ? '0 : row_reg;

        q_item.pixel   = pixel;
        q_item.col     = c;
        q_item.produce = (r >= sem_pkg::POS_W'(2)) && (c >= sem_pkg::POS_W'(2));
        q_item.row_o   = r - sem_pkg::POS_W'(1);
        q_item.col_o   = c - sem_pkg::POS_W'(1);
        q_item.last    = ({1'b0, r} == h_eff - sem_pkg::DIM_W'(1))
                      && ({1'b0, c} == w_eff - sem_pkg::DIM_W'(1));

        c_inc = {1'b0, c} + sem_pkg::DIM_W'(1);
        r_inc = {1'b0, r} + sem_pkg::DIM_W'(1);

        col_next = col_reg;
        row_next = row_reg;
        if (q_push)
        begin
            if (c_inc >= w_eff)
            begin
                col_next = '0;
                row_next = (r_inc >= h_eff) ? '0 : r_inc[sem_pkg::POS_W-1:0];
            end
            else
            begin
                col_next = c_inc[sem_pkg::POS_W-1:0];
                row_next = r;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= sem_pkg::DIM_W'(80);
            height_reg <= sem_pkg::DIM_W'(60);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

### rtl/sem_back.sv
// ----------------------------------------------------------------------------
// sem_back
// Reads the line store RAM, slides the 3x3 window, computes |Gx|+|Gy| and
// holds results in a two-entry output buffer.
// ----------------------------------------------------------------------------
module sem_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  sem_pkg::item_t            q_item,
    output logic                      q_pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output sem_pkg::res_t             out_res
);

    localparam int SUM_W = sem_pkg::PIX_W + 2;

    // Line store port signals
    logic                          ls_wr_en;
    logic [sem_pkg::LS_ADDR_W-1:0] ls_wr_addr;
    logic [sem_pkg::LS_DATA_W-1:0] ls_wr_data;
    logic [sem_pkg::LS_ADDR_W-1:0] ls_rd_addr;
    logic [sem_pkg::LS_DATA_W-1:0] ls_rd_data;

    // Compute stage
    logic                          s1_valid_reg;
    sem_pkg::item_t                s1_item_reg;
    logic                          byp_hit_reg, byp_hit_next;
    logic [sem_pkg::LS_DATA_W-1:0] byp_data_reg;
    logic [sem_pkg::PIX_W-1:0]     win_reg [6];

    logic [sem_pkg::PIX_W-1:0]     t2, m2, b2;
    logic [SUM_W-1:0]              sum_l, sum_r, sum_t, sum_b;
    logic signed [SUM_W:0]         gx, gy;
    logic [SUM_W-1:0]              abs_x, abs_y;
    logic [SUM_W:0]                mag;
    sem_pkg::res_t                 res;

    // Output buffer
    sem_pkg::res_t                 ob_reg [2];
    logic                          ob_wr_reg, ob_rd_reg;
    logic [1:0]                    ob_cnt_reg, ob_cnt_next;
    logic                          ob_push, ob_pop;
    logic [2:0]                    occ;

    sem_ram #(
        .DATA_W (sem_pkg::LS_DATA_W),
        .DEPTH  (sem_pkg::MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (ls_wr_en),
        .wr_addr (ls_wr_addr),
        .wr_data (ls_wr_data),
        .rd_en   (q_pop),
        .rd_addr (ls_rd_addr),
        .rd_data (ls_rd_data)
    );

    // Pop only when the output buffer has room for everything in flight
    assign ob_pop  = out_valid && out_ready;
    assign occ     = 3'(ob_cnt_reg) + 3'(s1_valid_reg) - 3'(ob_pop);
    assign q_pop   = q_valid && (occ <= 3'd1);

    assign ls_rd_addr = q_item.col[sem_pkg::LS_ADDR_W-1:0];
    assign ls_wr_en   = s1_valid_reg;
    assign ls_wr_addr = s1_item_reg.col[sem_pkg::LS_ADDR_W-1:0];
    assign ls_wr_data = {m2, b2};

    // Forward a write that lands on the slot being read in the same cycle
    assign byp_hit_next = q_pop && s1_valid_reg && (ls_rd_addr == ls_wr_addr);

    // Window column and gradients
    always_comb
    begin
        {t2, m2} = byp_hit_reg ? byp_data_reg : ls_rd_data;
        b2       = s1_item_reg.pixel;

        sum_r = SUM_W'(t2) + {1'b0, m2, 1'b0} + SUM_W'(b2);
        sum_l = SUM_W'(win_reg[0]) + {1'b0, win_reg[1], 1'b0} + SUM_W'(win_reg[2]);
        sum_t = SUM_W'(win_reg[0]) + {1'b0, win_reg[3], 1'b0} + SUM_W'(t2);
        sum_b = SUM_W'(win_reg[2]) + {1'b0, win_reg[5], 1'b0} + SUM_W'(b2);

        gx = signed'({1'b0, sum_r}) - signed'({1'b0, sum_l});
        gy = signed'({1'b0, sum_t}) - signed'({1'b0, sum_b});

        abs_x = gx[SUM_W] ? SUM_W'(-gx) : SUM_W'(gx);
        abs_y = gy[SUM_W] ? SUM_W'(-gy) : SUM_W'(gy);
        mag   = {1'b0, abs_x} + {1'b0, abs_y};

        res.edge_value = (mag > (SUM_W+1)'(255)) ? '1 : mag[sem_pkg::PIX_W-1:0];
        res.row        = s1_item_reg.row_o;
        res.col        = s1_item_reg.col_o;
        res.last       = s1_item_reg.last;
    end

    assign ob_push = s1_valid_reg && s1_item_reg.produce;

    // Compute stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            byp_hit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= q_pop;
            byp_hit_reg  <= byp_hit_next;
        end
    end

    // Compute stage payload and bypass data
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_item_reg  <= q_item;
            byp_data_reg <= ls_wr_data;
        end
    end

    // Slide the window one column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_valid_reg)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= t2;
            win_reg[4] <= m2;
            win_reg[5] <= b2;
        end
    end

    // Output buffer control
    assign ob_cnt_next = ob_cnt_reg + 2'(ob_push) - 2'(ob_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_wr_reg  <= 1'b0;
            ob_rd_reg  <= 1'b0;
            ob_cnt_reg <= 2'd0;
        end
        else
        begin
            ob_wr_reg  <= ob_push ? ~ob_wr_reg : ob_wr_reg;
            ob_rd_reg  <= ob_pop ? ~ob_rd_reg : ob_rd_reg;
            ob_cnt_reg <= ob_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ob_push)
        begin
            ob_reg[ob_wr_reg] <= res;
        end
    end

    assign out_valid = (ob_cnt_reg != 2'd0);
    assign out_res   = ob_reg[ob_rd_reg];

endmodule

### rtl/sobel_edge_magnitude.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// 3x3 Sobel gradient magnitude |Gx|+|Gy| over a raster pixel stream.
// ----------------------------------------------------------------------------
//  Channel | Handshake             | Payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_ready   | pixel, frame_start
//  out     | out_valid / out_ready | edge_value, out_row, out_col, frame_last
//  cfg     | cfg_wr_en             | cfg_index, cfg_data (write only)
//
//  One pixel per cycle sustained while out_ready holds. A result passes the
//  two-entry item queue, compute stage register and two-entry output buffer.
//  The single line store RAM (read and write each cycle) sets the rate.
//  Reset clears counters, window and queues, not the line store. Output
//  stalls fill the output buffer, then the item queue, before in_ready drops.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_index,
    input  logic [sem_pkg::DIM_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [sem_pkg::PIX_W-1:0] pixel,
    input  logic                      frame_start,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [sem_pkg::PIX_W-1:0] edge_value,
    output logic [sem_pkg::POS_W-1:0] out_row,
    output logic [sem_pkg::POS_W-1:0] out_col,
    output logic                      frame_last
);

    logic           q_not_full;
    logic           q_push;
    sem_pkg::item_t q_push_item;
    logic           q_pop;
    logic           q_valid;
    sem_pkg::item_t q_head;
    sem_pkg::res_t  out_res;

    sem_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel       (pixel),
        .frame_start (frame_start),
        .q_not_full  (q_not_full),
        .q_push      (q_push),
        .q_item      (q_push_item)
    );

    sem_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_push_item),
        .not_full   (q_not_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (q_head)
    );

    sem_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign edge_value = out_res.edge_value;
    assign out_row    = out_res.row;
    assign out_col    = out_res.col;
    assign frame_last = out_res.last;

endmodule

### dv/sobel_edge_magnitude_tb.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_tb
// Self-checking bench for the Sobel edge magnitude block. A short table of
// tiny frames comes first, then random frames at many geometries, the
// extremes among them. Every accepted pixel runs through a line-store and
// window model, and each result is compared with the oldest prediction.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sem_pkg::*;

    localparam int RESET_CYCLES  = 12;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 10;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int REPORT_MAX    = 10;

    // Directed stimulus: one pixel per row, with an optional typed result
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             fs;
        logic             chk;
        res_t             res;
    } stim_row_t;

    localparam res_t NO_RES   = '0;
    localparam res_t SAT_RES  = '{8'd255, 7'd1, 7'd1, 1'b1};
    localparam res_t FLAT_RES = '{8'd0, 7'd1, 7'd1, 1'b1};

    localparam int DIR_ROWS = 24;
    localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
        // 3x3 frame, dark left columns and bright right column
        '{8'd0,   1'b1, 1'b0, NO_RES},
        '{8'd0,   1'b0, 1'b0, NO_RES},
        '{8'd255, 1'b0, 1'b0, NO_RES},
        '{8'd0,   1'b0, 1'b0, NO_RES},
        '{8'd0,   1'b0, 1'b0, NO_RES},
        '{8'd255, 1'b0, 1'b0, NO_RES},
        '{8'd0,   1'b0, 1'b0, NO_RES},
        '{8'd0,   1'b0, 1'b0, NO_RES},
        '{8'd255, 1'b0, 1'b1, SAT_RES},
        // next frame starts by wrap, flat white
        '{8'd255, 1'b0, 1'b0, NO_RES},
        '{8'd255, 1'b0, 1'b0, NO_RES},
        '{8'd255, 1'b0, 1'b0, NO_RES},
        '{8'd255, 1'b0, 1'b0, NO_RES},
        '{8'd255, 1'b0, 1'b0, NO_RES},
        '{8'd255, 1'b0, 1'b0, NO_RES},
        '{8'd255, 1'b0, 1'b0, NO_RES},
        '{8'd255, 1'b0, 1'b0, NO_RES},
        '{8'd255, 1'b0, 1'b1, FLAT_RES},
        // frame restarts in the middle of a line
        '{8'd17,  1'b1, 1'b0, NO_RES},
        '{8'd128, 1'b0, 1'b0, NO_RES},
        '{8'd64,  1'b1, 1'b0, NO_RES},
        '{8'd1,   1'b0, 1'b0, NO_RES},
        '{8'd254, 1'b0, 1'b0, NO_RES},
        '{8'd90,  1'b0, 1'b0, NO_RES}
    };

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic             cfg_index;
    logic [DIM_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_ready;
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
    logic             out_valid;
    logic             out_ready;
    logic [PIX_W-1:0] edge_value;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             frame_last;

    // Model of the block
    logic [DIM_W-1:0] cur_width;
    logic [DIM_W-1:0] cur_height;
    logic [PIX_W-1:0] upper_line  [MAX_WIDTH];
    logic [PIX_W-1:0] middle_line [MAX_WIDTH];
    logic [PIX_W-1:0] win_pix     [6];
    logic [POS_W-1:0] col_pos;
    logic [POS_W-1:0] row_pos;

    res_t pending_edges [$];
    int   mismatch_count;
    int   rand_items;
    bit   burst_mode;

    sobel_edge_magnitude u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel       (pixel),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .edge_value  (edge_value),
        .out_row     (out_row),
        .out_col     (out_col),
        .frame_last  (frame_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
        if (v < DIM_MIN)
            return DIM_MIN;
        if (v > hi)
            return hi;
        return v;
    endfunction

    task automatic reset_model();
        cur_width  = 8'd80;
        cur_height = 8'd60;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        for (int i = 0; i < 6; i++)
            win_pix[i] = '0;
        col_pos = '0;
        row_pos = '0;
    endtask

    // Advance the window model by one pixel; return 1 when a result is due
    function automatic bit predict_edge(input logic [PIX_W-1:0] px, input logic fs,
                                        output res_t res);
        int unsigned w, h, c, r, slot, mag;
        int t0, m0, b0, t1, b1, t2, m2, b2, gx, gy;
        bit hit;
        w   = clamp_dim(cur_width, MAX_WIDTH);
        h   = clamp_dim(cur_height, MAX_HEIGHT);
        hit = 1'b0;
        res = '0;
        if (fs)
        begin
            col_pos = '0;
            row_pos = '0;
        end
        c    = col_pos;
        r    = row_pos;
        slot = c % MAX_WIDTH;
        t2   = upper_line[slot];
        m2   = middle_line[slot];
        b2   = px;

        // full window available: gradients at full precision
        if (r >= 2 && c >= 2)
        begin
            t0  = win_pix[0];
            m0  = win_pix[1];
            b0  = win_pix[2];
            t1  = win_pix[3];
            b1  = win_pix[5];
            gx  = (t2 + 2 * m2 + b2) - (t0 + 2 * m0 + b0);
            gy  = (t0 + 2 * t1 + t2) - (b0 + 2 * b1 + b2);
            mag = ((gx < 0) ? -gx : gx) + ((gy < 0) ? -gy : gy);
            if (mag > 255)
                mag = 255;
            res.edge_value = PIX_W'(mag);
            res.row        = POS_W'(r - 1);
            res.col        = POS_W'(c - 1);
            res.last       = (r == h - 1) && (c == w - 1);
            hit            = 1'b1;
        end

        // shift the window, update the line stores
        win_pix[0] = win_pix[3];
        win_pix[1] = win_pix[4];
        win_pix[2] = win_pix[5];
        win_pix[3] = PIX_W'(t2);
        win_pix[4] = PIX_W'(m2);
        win_pix[5] = px;
        upper_line[slot]  = PIX_W'(m2);
        middle_line[slot] = px;

        // advance the raster position
        c = c + 1;
        if (c >= w)
        begin
            c = 0;
            r = r + 1;
            if (r >= h)
                r = 0;
        end
        col_pos = POS_W'(c);
        row_pos = POS_W'(r);
        return hit;
    endfunction

    task automatic write_reg(input logic idx, input logic [DIM_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            cur_width = val;
        else
            cur_height = val;
    endtask

    // Offer one pixel item and hold it until accepted
    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs,
                              input logic chk, input res_t typed);
        int   gap;
        res_t res;
        bit   hit;
        gap = burst_mode ? 0 : pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        pixel       <= px;
        frame_start <= fs;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        hit = predict_edge(px, fs, res);
        if (hit)
            pending_edges.push_back(chk ? typed : res);
    endtask

    // Drop valid and wait for every predicted result, then let the pipe settle
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_edges.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One phase of random frames; shrink lowers the width mid-frame
    task automatic run_phase(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                             input int n_items, input bit shrink);
        int               style;
        int               base;
        logic [PIX_W-1:0] px;
        logic             fs;
        drain_results();
        write_reg(REG_IMAGE_WIDTH, w);
        if (!shrink)
            write_reg(REG_IMAGE_HEIGHT, h);
        burst_mode = ($urandom_range(0, 3) == 0);
        style      = $urandom_range(0, 2);
        base       = $urandom_range(0, 255);
        for (int i = 0; i < n_items; i++)
        begin
            case (style)
                0: px = PIX_W'($urandom_range(0, 255));
                1:
                begin
                    base = (base + $urandom_range(0, 2)) % 256;
                    px   = PIX_W'(base + $urandom_range(0, 7));
                end
                default: px = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            endcase
            if (i == 0)
                fs = !shrink;
            else
                fs = ($urandom_range(0, 99) < 3);
            send_pixel(px, fs, 1'b0, NO_RES);
            rand_items++;
            // hold off now and then until the output side is empty
            if ($urandom_range(0, 63) == 0)
                drain_results();
        end
    endtask

    // Result receiver backpressure
    initial
    begin : ready_drive
        int stall;
        int run;
        out_ready = 1'b0;
        forever
        begin
            if (burst_mode)
            begin
                @(negedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                stall = pick_gap();
                repeat (stall)
                begin
                    @(negedge clk);
                    out_ready <= 1'b0;
                end
                run = $urandom_range(1, 8);
                repeat (run)
                begin
                    @(negedge clk);
                    out_ready <= 1'b1;
                end
            end
        end
    end

    // Compare each accepted result with the oldest prediction
    initial
    begin : result_check
        res_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
            begin
                if (pending_edges.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected result: edge %0d row %0d col %0d last %0b",
                                 edge_value, out_row, out_col, frame_last);
                end
                else
                begin
                    want = pending_edges.pop_front();
                    if (want.edge_value !== edge_value || want.row !== out_row ||
                        want.col !== out_col || want.last !== frame_last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("mismatch: expected edge %0d row %0d col %0d last %0b, got edge %0d row %0d col %0d last %0b",
                                     want.edge_value, want.row, want.col, want.last,
                                     edge_value, out_row, out_col, frame_last);
                    end
                end
            end
        end
    end

    // End the run if nothing moves for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_ready === 1'b1) ||
                (out_valid === 1'b1 && out_ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    // Main sequence
    initial
    begin : stimulus
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = REG_IMAGE_WIDTH;
        cfg_data       = '0;
        in_valid       = 1'b0;
        pixel          = '0;
        frame_start    = 1'b0;
        burst_mode     = 1'b0;
        mismatch_count = 0;
        rand_items     = 0;
        reset_model();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table on the smallest frame
        write_reg(REG_IMAGE_WIDTH, 8'd3);
        write_reg(REG_IMAGE_HEIGHT, 8'd3);
        for (int i = 0; i < DIR_ROWS; i++)
            send_pixel(DIR_TAB[i].pix, DIR_TAB[i].fs, DIR_TAB[i].chk, DIR_TAB[i].res);

        // extremes and out-of-range geometry
        run_phase(8'd0,   8'd1,   30,  1'b0);
        run_phase(8'd129, 8'd2,   384, 1'b0);
        run_phase(8'd2,   8'd129, 384, 1'b0);
        run_phase(8'd80,  8'd60,  200, 1'b0);

        // width lowered in the middle of a frame
        run_phase(8'd16,  8'd6,   40,  1'b0);
        run_phase(8'd5,   8'd6,   50,  1'b1);

        // small random frames
        while (rand_items < RANDOM_ITEMS)
        begin
            automatic int w = $urandom_range(3, 12);
            automatic int h = $urandom_range(3, 8);
            run_phase(DIM_W'(w), DIM_W'(h), w * h * $urandom_range(1, 3) + $urandom_range(0, w),
                      1'b0);
        end

        drain_results();
        if (pending_edges.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### sobel_edge_magnitude.f
rtl/sem_pkg.sv
rtl/sem_ram.sv
rtl/sem_queue.sv
rtl/sem_front.sv
rtl/sem_back.sv
rtl/sobel_edge_magnitude.sv
dv/sobel_edge_magnitude_tb.sv
